FILE: rtl/core/cpft_pkg.sv
// ----------------------------------------------------------------------------
// cpft_pkg
// Shared types and constants of the character pair frequency table.
// ----------------------------------------------------------------------------
package cpft_pkg;

	// width of one stored pair key, first byte high, second byte low
	localparam int KEY_W = 16;

	// result status codes
	typedef enum logic [2:0] {
		ST_INC    = 3'd0,
		ST_NEW    = 3'd1,
		ST_FULL   = 3'd2,
		ST_READ   = 3'd3,
		ST_UNUSED = 3'd4
	} status_t;

endpackage

FILE: rtl/core/char_pair_frequency_table.sv
// A read item goes through S_READ and S_DONE to the output register (an unused index skips S_READ).
// A count item scans the used entries in S_SCAN: the single key compare on the
// table RAM read port checks one stored entry per cycle, in insertion order.
// Throughput: one item at a time; in_ready is high only between items.
// Reset: arst_n clears the fill count and the control state; the table RAM is not
// cleared, only entries below the fill count are ever used.
// ----------------------------------------------------------------------------
// char_pair_frequency_table
// Counts two-byte character pairs in an insertion-ordered table and lists it.
// ----------------------------------------------------------------------------
module char_pair_frequency_table #(
	parameter int TABLE_DEPTH = 1024,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             mode,
	input  logic [7:0]                       first_char,
	input  logic [7:0]                       second_char,
	input  logic [$clog2(TABLE_DEPTH)-1:0]   read_index,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       status,
	output logic [$clog2(TABLE_DEPTH)-1:0]   entry_index,
	output logic [7:0]                       entry_first,
	output logic [7:0]                       entry_second,
	output logic [COUNT_WIDTH-1:0]           entry_count,
	output logic [$clog2(TABLE_DEPTH+1)-1:0] used_entries
);

	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int USED_W  = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W   = cpft_pkg::KEY_W;
	localparam int ENTRY_W = KEY_W + COUNT_WIDTH;
	localparam logic [USED_W-1:0]      DEPTH_U   = USED_W'(TABLE_DEPTH);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic [USED_W-1:0]      used_q;
	logic [USED_W-1:0]      issue_q;
	logic                   pend_v_q;
	logic [IDX_W-1:0]       pend_idx_q;
	logic [KEY_W-1:0]       key_q;

	// staged result, waiting for the output register
	cpft_pkg::status_t      res_status_q;
	logic [IDX_W-1:0]       res_index_q;
	logic [7:0]             res_first_q;
	logic [7:0]             res_second_q;
	logic [COUNT_WIDTH-1:0] res_count_q;
	logic [USED_W-1:0]      res_used_q;

	// output register
	logic                   out_valid_q;
	cpft_pkg::status_t      out_status_q;
	logic [IDX_W-1:0]       out_index_q;
	logic [7:0]             out_first_q;
	logic [7:0]             out_second_q;
	logic [COUNT_WIDTH-1:0] out_count_q;
	logic [USED_W-1:0]      out_used_q;

	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [ENTRY_W-1:0]     ram_wdata;
	logic [IDX_W-1:0]       ram_raddr;
	logic [ENTRY_W-1:0]     ram_rdata;

	logic [KEY_W-1:0]       rd_key;
	logic [COUNT_WIDTH-1:0] rd_cnt;
	logic [COUNT_WIDTH-1:0] inc_cnt;
	logic                   issuing;
	logic                   hit;
	logic                   miss;
	logic                   room;
	logic                   in_range;

	// key and count table
	cpft_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// search pipeline: one read issued and one key compared per cycle
	assign rd_key   = ram_rdata[ENTRY_W-1 -: KEY_W];
	assign rd_cnt   = ram_rdata[COUNT_WIDTH-1:0];
	assign issuing  = (state_q == S_SCAN) && (issue_q < used_q);
	assign hit      = (state_q == S_SCAN) && pend_v_q && (rd_key == key_q);
	assign miss     = (state_q == S_SCAN) && !pend_v_q && !issuing;
	assign room     = used_q < DEPTH_U;
	assign in_range = USED_W'(read_index) < used_q;
	assign inc_cnt  = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_ONE;

	// table port selection
	assign ram_raddr = (state_q == S_IDLE) ? read_index : issue_q[IDX_W-1:0];
	assign ram_we    = hit || (miss && room);
	assign ram_waddr = hit ? pend_idx_q : used_q[IDX_W-1:0];
	assign ram_wdata = hit ? {key_q, inc_cnt} : {key_q, COUNT_ONE};

	// sequencer, fill count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			issue_q     <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						key_q       <= {first_char, second_char};
						res_index_q <= read_index;
						res_used_q  <= used_q;
						issue_q     <= '0;
						pend_v_q    <= 1'b0;
						if (mode) begin
							if (in_range) begin
								state_q <= S_READ;
							end else begin
								res_status_q <= cpft_pkg::ST_UNUSED;
								res_first_q  <= '0;
								res_second_q <= '0;
								res_count_q  <= '0;
								state_q      <= S_DONE;
							end
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_READ: begin
					res_status_q <= cpft_pkg::ST_READ;
					res_first_q  <= rd_key[15:8];
					res_second_q <= rd_key[7:0];
					res_count_q  <= rd_cnt;
					state_q      <= S_DONE;
				end
				S_SCAN: begin
					pend_v_q   <= issuing;
					pend_idx_q <= issue_q[IDX_W-1:0];
					if (issuing) begin
						issue_q <= issue_q + USED_W'(1);
					end
					if (hit) begin
						res_status_q <= cpft_pkg::ST_INC;
						res_index_q  <= pend_idx_q;
						res_first_q  <= key_q[15:8];
						res_second_q <= key_q[7:0];
						res_count_q  <= inc_cnt;
						res_used_q   <= used_q;
						state_q      <= S_DONE;
					end else if (miss) begin
						if (room) begin
							res_status_q <= cpft_pkg::ST_NEW;
							res_index_q  <= used_q[IDX_W-1:0];
							res_first_q  <= key_q[15:8];
							res_second_q <= key_q[7:0];
							res_count_q  <= COUNT_ONE;
							res_used_q   <= used_q + USED_W'(1);
							used_q       <= used_q + USED_W'(1);
						end else begin
							res_status_q <= cpft_pkg::ST_FULL;
							res_index_q  <= '0;
							res_first_q  <= '0;
							res_second_q <= '0;
							res_count_q  <= '0;
							res_used_q   <= used_q;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_index_q  <= res_index_q;
						out_first_q  <= res_first_q;
						out_second_q <= res_second_q;
						out_count_q  <= res_count_q;
						out_used_q   <= res_used_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign entry_index  = out_index_q;
	assign entry_first  = out_first_q;
	assign entry_second = out_second_q;
	assign entry_count  = out_count_q;
	assign used_entries = out_used_q;

	// fill count never passes the table depth
	assert property (@(posedge clk) disable iff (!arst_n) used_q <= DEPTH_U)
		else $error("fill count beyond table depth");

	// a new entry is always appended at the end of the used region
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == cpft_pkg::ST_NEW) |->
		(USED_W'(entry_index) + USED_W'(1) == used_entries))
		else $error("inserted entry not at end of table");

	// a dropped pair is only reported with a full table
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == cpft_pkg::ST_FULL) |-> (used_entries == DEPTH_U))
		else $error("drop reported with room left");

	// the table is only written at the end of a search
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_SCAN) ##1 (state_q == S_DONE))
		else $error("table write outside search");

endmodule

FILE: rtl/core/cpft_ram.sv
// ----------------------------------------------------------------------------
// cpft_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cpft_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sim/cpft_checker.sv
// ----------------------------------------------------------------------------
// cpft_checker
// Watches both channels of the character pair frequency table, keeps its own
// copy of the pair table, predicts each result on the input transfer and
// compares every output transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cpft_checker #(
	parameter int TABLE_DEPTH = 1024,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic                             mode,
	input  logic [7:0]                       first_char,
	input  logic [7:0]                       second_char,
	input  logic [$clog2(TABLE_DEPTH)-1:0]   read_index,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [2:0]                       status,
	input  logic [$clog2(TABLE_DEPTH)-1:0]   entry_index,
	input  logic [7:0]                       entry_first,
	input  logic [7:0]                       entry_second,
	input  logic [COUNT_WIDTH-1:0]           entry_count,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0] used_entries,
	output int                               fail_count,
	output int                               results_waiting
);

	localparam int IW    = $clog2(TABLE_DEPTH);
	localparam int UW    = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W = cpft_pkg::KEY_W;

	typedef struct packed {
		cpft_pkg::status_t      status;
		logic [IW-1:0]          index;
		logic [7:0]             first;
		logic [7:0]             second;
		logic [COUNT_WIDTH-1:0] count;
		logic [UW-1:0]          used;
	} tally_t;

	// shadow copy of the pair table
	logic [KEY_W-1:0]       shadow_keys [TABLE_DEPTH];
	logic [COUNT_WIDTH-1:0] shadow_counts [TABLE_DEPTH];
	int                     shadow_fill;

	tally_t pending_tallies [$];

	// apply one item to the shadow table and return the result it gives
	function automatic tally_t tally_pair(input logic is_read, input logic [7:0] a,
			input logic [7:0] b, input logic [IW-1:0] ridx);
		tally_t           r;
		logic [KEY_W-1:0] key;
		int               hit;
		r = '0;
		key = {a, b};
		hit = -1;
		if (is_read) begin
			r.index = ridx;
			if (ridx < shadow_fill) begin
				r.status = cpft_pkg::ST_READ;
				r.first  = shadow_keys[ridx][15:8];
				r.second = shadow_keys[ridx][7:0];
				r.count  = shadow_counts[ridx];
			end else begin
				r.status = cpft_pkg::ST_UNUSED;
			end
			r.used = UW'(shadow_fill);
			return r;
		end
		// linear search in insertion order, first match wins
		for (int i = 0; i < shadow_fill; i++) begin
			if (hit < 0 && shadow_keys[i] == key)
				hit = i;
		end
		if (hit >= 0) begin
			// saturating increment
			if (shadow_counts[hit] != '1)
				shadow_counts[hit] = shadow_counts[hit] + COUNT_WIDTH'(1);
			r.status = cpft_pkg::ST_INC;
			r.index  = IW'(hit);
			r.first  = a;
			r.second = b;
			r.count  = shadow_counts[hit];
		end else if (shadow_fill < TABLE_DEPTH) begin
			shadow_keys[shadow_fill]   = key;
			shadow_counts[shadow_fill] = COUNT_WIDTH'(1);
			r.status = cpft_pkg::ST_NEW;
			r.index  = IW'(shadow_fill);
			r.first  = a;
			r.second = b;
			r.count  = COUNT_WIDTH'(1);
			shadow_fill++;
		end else begin
			// table full: pair dropped, all entry fields zero
			r.status = cpft_pkg::ST_FULL;
		end
		r.used = UW'(shadow_fill);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// compare output transfers first, then record the new input transfer
	always @(posedge clk or negedge arst_n) begin
		tally_t want;
		if (!arst_n) begin
			shadow_fill = 0;
			fail_count = 0;
			pending_tallies.delete();
			results_waiting <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_tallies.size() == 0) begin
					$error("unexpected result: status %0d, entry_index %0d, entry_count %0d",
						status, entry_index, entry_count);
					fail_count++;
				end else begin
					want = pending_tallies.pop_front();
					check_field("status", want.status, status);
					check_field("entry_index", want.index, entry_index);
					check_field("entry_first", want.first, entry_first);
					check_field("entry_second", want.second, entry_second);
					check_field("entry_count", want.count, entry_count);
					check_field("used_entries", want.used, used_entries);
				end
			end
			if (in_valid && in_ready)
				pending_tallies.push_back(tally_pair(mode, first_char, second_char, read_index));
			results_waiting <= pending_tallies.size();
		end
	end

endmodule

FILE: sim/tb_char_pair_frequency_table.sv
// ----------------------------------------------------------------------------
// tb_char_pair_frequency_table
// Drives counts and reads into the pair table: a directed opening, a phase
// that pushes one pair to a high count, a phase that grows the table, and a
// closing mixed phase. Random gaps on the input and random stalls on the
// output; the checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module tb_char_pair_frequency_table;

	// block at its default size
	localparam int TABLE_DEPTH = 1024;
	localparam int COUNT_WIDTH = 32;
	localparam int IW          = $clog2(TABLE_DEPTH);
	localparam int UW          = $clog2(TABLE_DEPTH + 1);
	localparam int MAX_CYCLES  = 4000000;

	localparam logic MODE_COUNT = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic                   mode;
	logic [7:0]             first_char;
	logic [7:0]             second_char;
	logic [IW-1:0]          read_index;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [2:0]             status;
	logic [IW-1:0]          entry_index;
	logic [7:0]             entry_first;
	logic [7:0]             entry_second;
	logic [COUNT_WIDTH-1:0] entry_count;
	logic [UW-1:0]          used_entries;

	int            fail_count;
	int            results_waiting;
	int            cycle_count = 0;
	int            rx_hold = 0;
	logic          rx_stalls_on = 1'b1;
	logic          tx_gaps_on;
	logic [UW-1:0] used_seen = '0;
	logic          table_full;

	assign table_full = (used_seen == TABLE_DEPTH);

	char_pair_frequency_table #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .first_char(first_char), .second_char(second_char),
		.read_index(read_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .entry_index(entry_index),
		.entry_first(entry_first), .entry_second(entry_second),
		.entry_count(entry_count), .used_entries(used_entries)
	);

	cpft_checker #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .first_char(first_char), .second_char(second_char),
		.read_index(read_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .entry_index(entry_index),
		.entry_first(entry_first), .entry_second(entry_second),
		.entry_count(entry_count), .used_entries(used_entries),
		.fail_count(fail_count), .results_waiting(results_waiting)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == MAX_CYCLES) begin
			$display("** char_pair_frequency_table: FAILED **");
			$finish;
		end
	end

	// mostly short idle stretches, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// byte from a set of corner values
	function automatic logic [7:0] pick_byte();
		logic [7:0] corners [6];
		corners = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
		return corners[$urandom_range(0, 5)];
	endfunction

	// read index, mostly inside or just past the used part
	function automatic logic [IW-1:0] pick_read_index();
		if ($urandom_range(0, 99) < 70)
			return IW'($urandom_range(0, used_seen));
		return IW'($urandom_range(0, (1 << IW) - 1));
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
		end else if (!rx_stalls_on || $urandom_range(0, 1)) begin
			out_ready <= 1'b1;
			rx_hold <= $urandom_range(0, 5);
		end else begin
			out_ready <= 1'b0;
			rx_hold <= idle_len();
		end
	end

	// fill level as reported on the output channel
	always @(posedge clk) begin
		if (out_valid && out_ready)
			used_seen <= used_entries;
	end

	// one input transfer, optionally after an idle gap
	task automatic send_item(input logic m, input logic [7:0] a, input logic [7:0] b,
			input logic [IW-1:0] ridx);
		int gap;
		gap = tx_gaps_on ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		first_char  <= a;
		second_char <= b;
		read_index  <= ridx;
		do @(posedge clk); while (!in_ready);
	endtask

	initial begin
		int r;
		int n;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		mode        = MODE_COUNT;
		first_char  = 8'h00;
		second_char = 8'h00;
		read_index  = '0;
		tx_gaps_on  = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty reads, corner pairs, inserts, increments, reads
		send_item(MODE_READ, 8'hFF, 8'hFF, '0);
		send_item(MODE_READ, 8'h00, 8'h00, '1);
		send_item(MODE_COUNT, 8'h00, 8'h00, '1);
		send_item(MODE_COUNT, 8'hFF, 8'hFF, '0);
		send_item(MODE_COUNT, 8'h00, 8'h00, '0);
		send_item(MODE_COUNT, 8'h00, 8'hFF, IW'(10'h155));
		send_item(MODE_COUNT, 8'hFF, 8'h00, IW'(10'h2AA));
		send_item(MODE_COUNT, 8'hFF, 8'hFF, '1);
		send_item(MODE_COUNT, 8'h55, 8'hAA, '0);
		send_item(MODE_COUNT, 8'hAA, 8'h55, '0);
		send_item(MODE_READ, 8'hFF, 8'hFF, IW'(0));
		send_item(MODE_READ, 8'h55, 8'hAA, IW'(5));
		send_item(MODE_READ, 8'h00, 8'h00, IW'(6));
		send_item(MODE_READ, 8'h00, 8'h00, '1);
		send_item(MODE_READ, 8'hAA, 8'h55, IW'(10'h155));
		send_item(MODE_READ, 8'h55, 8'hAA, IW'(10'h2AA));
		send_item(MODE_COUNT, 8'h55, 8'hAA, '1);
		send_item(MODE_COUNT, 8'h00, 8'h00, '0);

		// drive the first pair to a high count among a few corner pairs
		for (n = 0; n < 200; n++) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				send_item(MODE_READ, 8'($urandom), 8'($urandom), pick_read_index());
			else if (r < 92)
				send_item(MODE_COUNT, 8'h00, 8'h00, IW'($urandom));
			else
				send_item(MODE_COUNT, pick_byte(), pick_byte(), IW'($urandom));
		end

		// grow the table, the first stretch without any idling
		tx_gaps_on = 1'b0;
		rx_stalls_on <= 1'b0;
		for (n = 0; n < 320 && !table_full; n++) begin
			if (n == 100) begin
				tx_gaps_on = 1'b1;
				rx_stalls_on <= 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 5)
				send_item(MODE_READ, 8'($urandom), 8'($urandom), pick_read_index());
			else if (r < 10)
				send_item(MODE_COUNT, pick_byte(), pick_byte(), IW'($urandom));
			else
				send_item(MODE_COUNT, 8'($urandom), 8'($urandom), IW'($urandom));
		end
		tx_gaps_on = 1'b1;
		rx_stalls_on <= 1'b1;

		// mixed: new pairs, increments, reads across the whole index range
		for (n = 0; n < 45; n++) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				send_item(MODE_READ, 8'($urandom), 8'($urandom), pick_read_index());
			else if (r < 65)
				send_item(MODE_COUNT, 8'($urandom), 8'($urandom), IW'($urandom));
			else if (r < 80)
				send_item(MODE_COUNT, 8'h00, 8'h00, IW'($urandom));
			else
				send_item(MODE_COUNT, pick_byte(), pick_byte(), IW'($urandom));
		end
		in_valid <= 1'b0;

		// drain, then watch for stray results
		@(posedge clk);
		while (results_waiting != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		if (fail_count == 0)
			$display("** char_pair_frequency_table: PASSED **");
		else
			$display("** char_pair_frequency_table: FAILED **");
		$finish;
	end

endmodule
